// File: rtl/wcs_pkg.sv
package wcs_pkg;

  localparam int MaxChildren = 32;
  localparam int SlotBits    = $clog2(MaxChildren);
  localparam int CountBits   = SlotBits + 1;
  localparam int IdBits      = 16;
  localparam int WeightBits  = 16;
  localparam int TotalBits   = 21;
  localparam int IdxBits     = 6;
  localparam int EntryBits   = IdBits + WeightBits;

  typedef enum logic [2:0] {
    OP_PICK     = 3'd0,
    OP_INSERT   = 3'd1,
    OP_ROTATE   = 3'd2,
    OP_SET_SLOT = 3'd3,
    OP_SET_ID   = 3'd4,
    OP_REM_SLOT = 3'd5,
    OP_REM_ID   = 3'd6,
    OP_RECOMPUTE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]          operation;
    logic [IdxBits-1:0]  slot_index;
    logic [IdxBits-1:0]  middle_index;
    logic [IdxBits-1:0]  end_index;
    logic [IdBits-1:0]   child_id;
    logic [15:0]         child_weight;
    logic [TotalBits-1:0] pick_value;
  } wcs_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [4:0]           picked_slot;
    logic [IdBits-1:0]    picked_id;
    logic [TotalBits-1:0] total_weight;
    logic [5:0]           entry_count;
  } wcs_out_t;

  typedef struct packed {
    logic                 we;
    logic [SlotBits-1:0]  waddr;
    logic [EntryBits-1:0] wdata;
    logic [SlotBits-1:0]  raddr;
  } wcs_mem_req_t;

endpackage

// File: rtl/wcs_ram.sv
module wcs_ram import wcs_pkg::*; (
  input  logic                 clk_i,
  input  wcs_mem_req_t         req_i,
  output logic [EntryBits-1:0] rdata_o
);

  logic [EntryBits-1:0] mem [MaxChildren];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// File: rtl/wcs_ctrl.sv
module wcs_ctrl import wcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 random_mode_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wcs_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wcs_out_t             out_data_o,
  output wcs_mem_req_t         mem_o,
  input  logic [EntryBits-1:0] rdata_i
);

  // One-hot sequencer. A scan reads slot i while the data of slot i-1 arrives.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_ROT   = 6'b001000,
    S_ROTW  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  localparam logic [CountBits-1:0] Full = CountBits'(MaxChildren);

  state_e                 state_q, state_d;
  wcs_in_t                op_q, op_d;
  logic [CountBits-1:0]   count_q, count_d;
  logic [TotalBits-1:0]   total_q, total_d;
  logic [CountBits-1:0]   ptr_q, ptr_d;
  logic [CountBits-1:0]   idx_q, idx_d;    // address issued for read
  logic [CountBits-1:0]   lim_q, lim_d;    // end of sweep
  logic [CountBits-1:0]   pos_q, pos_d;    // remove write position; rotate pass count
  logic                   rv_q, rv_d;      // read data is valid this cycle
  logic [TotalBits-1:0]   cum_q, cum_d;
  logic [1:0]             st_q, st_d;
  logic [4:0]             pslot_q, pslot_d;
  logic [IdBits-1:0]      pid_q, pid_d;
  logic                   ovalid_q, ovalid_d;
  wcs_out_t               out_q, out_d;
  logic                   found_q, found_d;
  logic [CountBits-1:0]   hit_q, hit_d;
  logic [EntryBits-1:0]   buf_q, buf_d;    // held entry for insert ripple and rotate

  logic [CountBits-1:0]   rd_slot;         // slot whose data is on rdata_i
  logic [WeightBits-1:0]  rw;
  logic [IdBits-1:0]      rid;
  logic [CountBits-1:0]   slot6, mid6, end6;

  assign rid   = rdata_i[EntryBits-1 -: IdBits];
  assign rw    = rdata_i[WeightBits-1:0];
  assign slot6 = CountBits'(op_q.slot_index);
  assign mid6  = CountBits'(op_q.middle_index);
  assign end6  = CountBits'(op_q.end_index);
  assign rd_slot = idx_q - CountBits'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q; op_d = op_q; count_d = count_q; total_d = total_q;
    ptr_d = ptr_q; idx_d = idx_q; lim_d = lim_q; pos_d = pos_q; rv_d = 1'b0;
    cum_d = cum_q; st_d = st_q; pslot_d = pslot_q; pid_d = pid_q;
    found_d = found_q; hit_d = hit_q; buf_d = buf_q;
    ovalid_d = ovalid_q && out_stall_i; out_d = out_q;
    mem_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i; st_d = ST_OK; pslot_d = '0; pid_d = '0;
          cum_d = '0; found_d = 1'b0; idx_d = '0; pos_d = '0;
          state_d = S_DONE;
          case (op_e'(in_data_i.operation))
            OP_PICK: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else if (random_mode_i) begin
                st_d = ST_EMPTY; lim_d = count_q; state_d = S_SCAN;
              end else begin
                idx_d = (ptr_q >= count_q) ? '0 : ptr_q;
                lim_d = idx_d + CountBits'(1); state_d = S_SCAN;
              end
            end
            OP_INSERT: begin
              if (count_q >= Full) begin
                st_d = ST_FULL;
              end else begin
                pos_d = (CountBits'(in_data_i.slot_index) > count_q) ? count_q
                        : CountBits'(in_data_i.slot_index);
                idx_d = pos_d; lim_d = count_q + CountBits'(1);
                buf_d = {in_data_i.child_id, in_data_i.child_weight};
                total_d = total_q + TotalBits'(in_data_i.child_weight);
                count_d = count_q + CountBits'(1);
                state_d = S_SHIFT;
              end
            end
            OP_ROTATE: begin
              if (CountBits'(in_data_i.end_index) > count_q ||
                  in_data_i.middle_index >= in_data_i.end_index ||
                  in_data_i.slot_index >= in_data_i.middle_index) begin
                st_d = ST_BAD;
              end else begin
                // The range is rotated left one step per pass, mid-first passes.
                pos_d = CountBits'(in_data_i.slot_index);
                state_d = S_ROT;
              end
            end
            OP_SET_SLOT, OP_REM_SLOT: begin
              if (CountBits'(in_data_i.slot_index) >= count_q) begin
                st_d = ST_BAD;
              end else begin
                idx_d = CountBits'(in_data_i.slot_index);
                lim_d = idx_d + CountBits'(1); state_d = S_SCAN;
              end
            end
            default: begin
              lim_d = count_q; state_d = S_SCAN;
              if (op_e'(in_data_i.operation) == OP_RECOMPUTE) total_d = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read phase issues idx; data of idx-1 is evaluated when rv_q.
        if (idx_q < lim_q && !found_q) begin
          mem_o.raddr = idx_q[SlotBits-1:0];
          idx_d = idx_q + CountBits'(1);
          rv_d = 1'b1;
        end
        if (rv_q && !found_q) begin
          case (op_e'(op_q.operation))
            OP_PICK: begin
              if (random_mode_i) begin
                cum_d = cum_q + TotalBits'(rw);
                if (op_q.pick_value < cum_d) begin
                  found_d = 1'b1; st_d = ST_OK;
                  pslot_d = rd_slot[4:0]; pid_d = rid;
                end
              end else begin
                found_d = 1'b1; pslot_d = rd_slot[4:0]; pid_d = rid;
                ptr_d = rd_slot + CountBits'(1);
              end
            end
            OP_RECOMPUTE: total_d = total_q + TotalBits'(rw);
            OP_SET_SLOT, OP_SET_ID, OP_REM_SLOT, OP_REM_ID: begin
              if (op_e'(op_q.operation) == OP_SET_SLOT ||
                  op_e'(op_q.operation) == OP_REM_SLOT || rid == op_q.child_id) begin
                found_d = 1'b1; hit_d = rd_slot;
                if (op_e'(op_q.operation) == OP_SET_SLOT ||
                    op_e'(op_q.operation) == OP_SET_ID) begin
                  total_d = total_q + TotalBits'(op_q.child_weight) - TotalBits'(rw);
                  mem_o.we = 1'b1; mem_o.waddr = rd_slot[SlotBits-1:0];
                  mem_o.wdata = {rid, op_q.child_weight};
                end else begin
                  total_d = total_q - TotalBits'(rw);
                end
              end
            end
            default: ;
          endcase
        end
        if (!rv_q && (idx_q >= lim_q || found_q)) begin
          state_d = S_DONE;
          if (!found_q && op_e'(op_q.operation) != OP_PICK &&
              op_e'(op_q.operation) != OP_RECOMPUTE) begin
            st_d = ST_BAD;
          end
          if (found_q && (op_e'(op_q.operation) == OP_REM_SLOT ||
                          op_e'(op_q.operation) == OP_REM_ID)) begin
            // Close the gap: copy slot+1 down to slot.
            idx_d = hit_q + CountBits'(1); lim_d = count_q; pos_d = hit_q;
            count_d = count_q - CountBits'(1);
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (op_e'(op_q.operation) == OP_INSERT) begin
          // Ripple upward: write held entry at the slot just read, carry the old one.
          if (rv_q) begin
            mem_o.we = 1'b1; mem_o.waddr = rd_slot[SlotBits-1:0];
            mem_o.wdata = buf_q; buf_d = rdata_i;
          end
          if (idx_q < lim_q && !rv_q) begin
            mem_o.raddr = idx_q[SlotBits-1:0];
            idx_d = idx_q + CountBits'(1); rv_d = 1'b1;
          end else if (!rv_q) begin
            state_d = S_DONE;
          end
        end else begin
          if (rv_q) begin
            mem_o.we = 1'b1; mem_o.waddr = pos_q[SlotBits-1:0]; mem_o.wdata = rdata_i;
            pos_d = pos_q + CountBits'(1);
          end
          if (idx_q < lim_q && !rv_q) begin
            mem_o.raddr = idx_q[SlotBits-1:0];
            idx_d = idx_q + CountBits'(1); rv_d = 1'b1;
          end else if (!rv_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_ROT: begin
        // Rotate by repeated left shift of the range by one, mid-first times.
        // Each pass: buffer the first entry, shift down, write buffer at end-1.
        if (pos_q >= mid6) begin
          state_d = S_DONE;
        end else begin
          mem_o.raddr = slot6[SlotBits-1:0];
          rv_d = 1'b1; idx_d = slot6 + CountBits'(1); lim_d = slot6;
          state_d = S_ROTW;
        end
      end
      S_ROTW: begin
        if (rv_q && lim_q == slot6 && idx_q == slot6 + CountBits'(1) && !found_q) begin
          buf_d = rdata_i; found_d = 1'b1;
        end else if (rv_q) begin
          mem_o.we = 1'b1; mem_o.waddr = lim_q[SlotBits-1:0]; mem_o.wdata = rdata_i;
          lim_d = lim_q + CountBits'(1);
        end
        if (!rv_q) begin
          if (idx_q < end6) begin
            mem_o.raddr = idx_q[SlotBits-1:0];
            idx_d = idx_q + CountBits'(1); rv_d = 1'b1;
          end else begin
            mem_o.we = 1'b1; mem_o.waddr = lim_q[SlotBits-1:0]; mem_o.wdata = buf_q;
            found_d = 1'b0; pos_d = pos_q + CountBits'(1);
            state_d = S_ROT;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          out_d.status = st_q; out_d.picked_slot = pslot_q; out_d.picked_id = pid_q;
          out_d.total_weight = total_q; out_d.entry_count = 6'(count_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; total_q <= '0; ptr_q <= '0;
      ovalid_q <= 1'b0; rv_q <= 1'b0; found_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; total_q <= total_d; ptr_q <= ptr_d;
      ovalid_q <= ovalid_d; rv_q <= rv_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; idx_q <= idx_d; lim_q <= lim_d; pos_q <= pos_d; cum_q <= cum_d;
    st_q <= st_d; pslot_q <= pslot_d; pid_q <= pid_d; out_q <= out_d;
    hit_q <= hit_d; buf_q <= buf_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full) else $error("entry count above capacity");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_o.we) else $error("memory write while idle");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_DONE)) else $error("result without done");

endmodule

// File: rtl/weighted_child_selector_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | in_data_i (wcs_in_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (wcs_out_t)
// cfg     | input     | cfg_we_i             | cfg_data_i (random_mode)
// One item at a time. Weighted pick, lookup by id and recompute sweep the entries; insert
// and remove ripple the entries above the slot, and rotate makes mid-first shift passes
// over the range; one memory read port paces it.
// Reset clears count, sum, pointer and the mode; the memory is left unwritten.
// A stalled result holds; the next item is taken the cycle after a result is loaded.
module weighted_child_selector_core import wcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wcs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wcs_out_t out_data_o
);

  logic                 mode_q;
  wcs_mem_req_t         mem_req;
  logic [EntryBits-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  wcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .random_mode_i(mode_q), .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .mem_o(mem_req), .rdata_i(rdata)
  );

  wcs_ram u_ram (.clk_i, .req_i(mem_req), .rdata_o(rdata));

endmodule

// File: sim/testbench.sv
module testbench;
  import wcs_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_data_i;
  logic     in_valid_i;
  logic     in_stall_o;
  wcs_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  wcs_out_t out_data_o;

  weighted_child_selector_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  localparam int WatchdogLimit = 20000;
  localparam int InBits = $bits(wcs_in_t);

  // Shadow copy of the child table.
  logic [IdBits-1:0]     shadow_ids [MaxChildren];
  logic [WeightBits-1:0] shadow_wts [MaxChildren];
  int unsigned           shadow_count;
  logic [TotalBits-1:0]  shadow_total;
  int unsigned           shadow_ptr;
  logic                  weighted_mode;

  wcs_out_t pending_results[$];
  int       mismatches;
  int       results_seen;
  int       picks_ok;
  int       idle_cycles;
  int       sender_idle_pct;
  int       receiver_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int lowest_slot_of(logic [IdBits-1:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int unsigned s);
    shadow_total = shadow_total - shadow_wts[s];
    for (int unsigned i = s; i + 1 < shadow_count; i++) begin
      shadow_ids[i] = shadow_ids[i+1];
      shadow_wts[i] = shadow_wts[i+1];
    end
    shadow_count--;
  endfunction

  function automatic wcs_out_t apply_operation(wcs_in_t it);
    wcs_out_t r;
    int unsigned s, m, e, len, sh;
    int f;
    logic [31:0] cum;
    logic [IdBits-1:0] tid [MaxChildren];
    logic [WeightBits-1:0] tw [MaxChildren];
    r = '0;
    r.status = ST_OK;
    s = it.slot_index;
    m = it.middle_index;
    e = it.end_index;
    case (op_e'(it.operation))
      OP_PICK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (weighted_mode) begin
          cum = 0;
          r.status = ST_EMPTY;
          for (int unsigned i = 0; i < shadow_count; i++) begin
            cum += shadow_wts[i];
            if (it.pick_value < cum) begin
              r.status = ST_OK;
              r.picked_slot = 5'(i);
              r.picked_id = shadow_ids[i];
              break;
            end
          end
        end else begin
          if (shadow_ptr >= shadow_count) shadow_ptr = 0;
          r.picked_slot = 5'(shadow_ptr);
          r.picked_id = shadow_ids[shadow_ptr];
          shadow_ptr++;
        end
      end
      OP_INSERT: begin
        if (shadow_count >= MaxChildren) begin
          r.status = ST_FULL;
        end else begin
          if (s > shadow_count) s = shadow_count;
          for (int unsigned i = shadow_count; i > s; i--) begin
            shadow_ids[i] = shadow_ids[i-1];
            shadow_wts[i] = shadow_wts[i-1];
          end
          shadow_ids[s] = it.child_id;
          shadow_wts[s] = it.child_weight;
          shadow_count++;
          shadow_total = shadow_total + it.child_weight;
        end
      end
      OP_ROTATE: begin
        if (e > shadow_count || m >= e || s >= m) begin
          r.status = ST_BAD;
        end else begin
          len = e - s;
          sh = m - s;
          for (int unsigned i = 0; i < len; i++) begin
            tid[i] = shadow_ids[s + (i + sh) % len];
            tw[i] = shadow_wts[s + (i + sh) % len];
          end
          for (int unsigned i = 0; i < len; i++) begin
            shadow_ids[s+i] = tid[i];
            shadow_wts[s+i] = tw[i];
          end
        end
      end
      OP_SET_SLOT, OP_SET_ID: begin
        f = (it.operation == OP_SET_SLOT) ? ((s < shadow_count) ? int'(s) : -1)
                                          : lowest_slot_of(it.child_id);
        if (f < 0) begin
          r.status = ST_BAD;
        end else begin
          shadow_total = shadow_total + it.child_weight - shadow_wts[f];
          shadow_wts[f] = it.child_weight;
        end
      end
      OP_REM_SLOT, OP_REM_ID: begin
        f = (it.operation == OP_REM_SLOT) ? ((s < shadow_count) ? int'(s) : -1)
                                          : lowest_slot_of(it.child_id);
        if (f < 0) r.status = ST_BAD;
        else drop_slot(f);
      end
      default: begin
        shadow_total = '0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          shadow_total = shadow_total + shadow_wts[i];
        end
      end
    endcase
    r.total_weight = shadow_total;
    r.entry_count = 6'(shadow_count);
    return r;
  endfunction

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    wcs_out_t exp_r;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("Mismatches found");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", out_data_o);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data_o.status != exp_r.status ||
              out_data_o.picked_slot != exp_r.picked_slot ||
              out_data_o.picked_id != exp_r.picked_id ||
              out_data_o.total_weight != exp_r.total_weight ||
              out_data_o.entry_count != exp_r.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result mismatch: expected %p, got %p", exp_r, out_data_o);
            end
          end
        end
      end
    end
  end

  // The receiver stalls at random at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni ? ($urandom_range(99) < receiver_idle_pct) : 1'b0;
  end

  // Valid stays up after the accepting edge until the next item or a drain replaces it;
  // the block is busy by then, so the old item is never taken twice.
  task automatic send_item(wcs_in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_operation(it));
    if (op_e'(it.operation) == OP_PICK && pending_results[$].status == ST_OK) picks_ok++;
    @(negedge clk_i);
  endtask

  task automatic send_op(op_e op, int unsigned s, int unsigned m, int unsigned e,
                         int unsigned id, int unsigned w, int unsigned pv);
    wcs_in_t it;
    it.operation = op;
    it.slot_index = IdxBits'(s);
    it.middle_index = IdxBits'(m);
    it.end_index = IdxBits'(e);
    it.child_id = IdBits'(id);
    it.child_weight = 16'(w);
    it.pick_value = TotalBits'(pv);
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    weighted_mode = mode;
  endtask

  task automatic test_directed();
    send_op(OP_PICK, 0, 0, 0, 16'h0, 16'h0, '0);
    send_op(OP_REM_SLOT, 0, 0, 0, 16'h0, 16'h0, '0);
    send_op(OP_REM_ID, 0, 0, 0, 16'h1234, 16'h0, '0);
    send_op(OP_INSERT, 63, 0, 0, 16'hFFFF, 16'hFFFF, '0);
    send_op(OP_INSERT, 0, 0, 0, 16'h0000, 16'h0000, '0);
    send_op(OP_INSERT, 1, 0, 0, 16'hFFFF, 16'h0005, '0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, '0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, '0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, '0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, '0);
    send_op(OP_ROTATE, 0, 1, 3, 0, 0, '0);
    send_op(OP_ROTATE, 1, 1, 3, 0, 0, '0);
    send_op(OP_ROTATE, 0, 3, 3, 0, 0, '0);
    send_op(OP_ROTATE, 0, 1, 4, 0, 0, '0);
    send_op(OP_SET_SLOT, 2, 0, 0, 0, 16'h0, '0);
    send_op(OP_SET_SLOT, 3, 0, 0, 0, 16'h1, '0);
    send_op(OP_SET_ID, 0, 0, 0, 16'hFFFF, 16'h8000, '0);
    send_op(OP_SET_ID, 0, 0, 0, 16'h4321, 16'h8000, '0);
    send_op(OP_RECOMPUTE, 0, 0, 0, 0, 0, '0);
    write_mode(1'b1);
    send_op(OP_PICK, 0, 0, 0, 0, 0, 21'd0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, 21'h1FFFFF);
    send_op(OP_REM_ID, 0, 0, 0, 16'hFFFF, 0, '0);
    send_op(OP_REM_SLOT, 0, 0, 0, 0, 0, '0);
    send_op(OP_REM_SLOT, 0, 0, 0, 0, 0, '0);
    send_op(OP_PICK, 0, 0, 0, 0, 0, 21'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < MaxChildren + 2; i++) begin
      send_op(OP_INSERT, $urandom_range(63), 0, 0, $urandom, 16'hFFFF, '0);
    end
    send_op(OP_PICK, 0, 0, 0, 0, 0, shadow_total - 1);
    send_op(OP_PICK, 0, 0, 0, 0, 0, shadow_total);
    send_op(OP_ROTATE, 0, 31, 32, 0, 0, '0);
    send_op(OP_ROTATE, 0, 1, 32, 0, 0, '0);
    while (shadow_count > 0) send_op(OP_REM_SLOT, $urandom_range(31), 0, 0, 0, 0, '0);
  endtask

  // Random operations, kept mostly legal so the table stays populated.
  task automatic random_ops(int n);
    wcs_in_t it;
    int unsigned c, e;
    for (int k = 0; k < n; k++) begin
      it = InBits'({$urandom, $urandom, $urandom});
      c = shadow_count;
      if ($urandom_range(9) < 8) begin
        it.operation = 3'($urandom_range(7));
        if (c < 4 || $urandom_range(3) == 0) it.operation = OP_INSERT;
        if (c > 20 && $urandom_range(1)) it.operation = OP_REM_SLOT;
        if (c > 0) begin
          it.slot_index = IdxBits'($urandom_range(c - 1));
          if (it.operation == OP_SET_ID || it.operation == OP_REM_ID)
            it.child_id = shadow_ids[$urandom_range(c - 1)];
        end
        if (it.operation == OP_INSERT) it.child_id = IdBits'($urandom_range(15));
        if (it.operation == OP_ROTATE && c >= 2) begin
          e = $urandom_range(c, 2);
          it.slot_index = IdxBits'($urandom_range(e - 2));
          it.middle_index = IdxBits'($urandom_range(e - 1, it.slot_index + 1));
          it.end_index = IdxBits'(e);
        end
        if (it.operation == OP_PICK)
          it.pick_value = (shadow_total == 0) ? '0
                          : TotalBits'($urandom_range(shadow_total - 1));
        if ($urandom_range(7) == 0) it.child_weight = '0;
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    picks_ok = 0;
    shadow_count = 0;
    shadow_total = '0;
    shadow_ptr = 0;
    weighted_mode = 1'b0;
    sender_idle_pct = 32;
    receiver_idle_pct = 71;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    write_mode(1'b0);
    test_full_table();
    random_ops(180);
    sender_idle_pct = 71;
    receiver_idle_pct = 32;
    write_mode(1'b1);
    random_ops(180);
    // Hold off until the block has returned everything.
    drain_results();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_mode(1'b0);
    random_ops(100);
    write_mode(1'b1);
    random_ops(100);
    drain_results();

    $display("Covered %0d results, %0d successful picks, both pick modes.",
             results_seen, picks_ok);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
